### sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and types for the lru page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 8;
    localparam int FRAME_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_BITS  = FRAME_BITS;

    // port field widths
    localparam int PAGE_W  = 8;
    localparam int INDEX_W = 2;
    localparam int COUNT_W = 32;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 80;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [FRAME_BITS-1:0] frame_idx_t;
    typedef logic [RANK_BITS-1:0]  rank_t;

    // lookup record handed from one cell to the next
    typedef struct packed {
        logic       hit;
        frame_idx_t hit_idx;
        rank_t      hit_rank;
        logic       empty;
        frame_idx_t empty_idx;
        rank_t      empty_rank;
        logic       best_set;
        frame_idx_t best_idx;
        rank_t      best_rank;
        page_t      best_page;
    } scan_t;

    // update broadcast to every cell
    typedef struct packed {
        logic       en;
        logic       load;
        frame_idx_t chosen;
        rank_t      old_rank;
        page_t      page;
    } upd_t;

endpackage

`default_nettype wire

### sv/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell
// one frame: page, valid mark and recency rank, plus its step of the lookup
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lrupr_pkg::frame_idx_t cell_idx,
    input  wire lrupr_pkg::page_t     page_in,
    input  wire lrupr_pkg::scan_t     scan_in,
    output lrupr_pkg::scan_t          scan_out,
    input  wire lrupr_pkg::upd_t      upd
);
    import lrupr_pkg::*;

    page_t page_reg;
    logic  valid_reg;
    rank_t rank_reg;

    always_comb begin
        scan_out = scan_in;
        if (!scan_in.hit && valid_reg && (page_reg == page_in)) begin
            scan_out.hit      = 1'b1;
            scan_out.hit_idx  = cell_idx;
            scan_out.hit_rank = rank_reg;
        end
        if (!scan_in.empty && !valid_reg) begin
            scan_out.empty      = 1'b1;
            scan_out.empty_idx  = cell_idx;
            scan_out.empty_rank = rank_reg;
        end
        // strictly greater keeps the lowest index on a tie
        if (!scan_in.best_set || (rank_reg > scan_in.best_rank)) begin
            scan_out.best_set  = 1'b1;
            scan_out.best_idx  = cell_idx;
            scan_out.best_rank = rank_reg;
            scan_out.best_page = page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= rank_t'(cell_idx);
        end else if (upd.en) begin
            if (upd.chosen == cell_idx) begin
                rank_reg <= '0;
                if (upd.load) begin
                    page_reg  <= upd.page;
                    valid_reg <= 1'b1;
                end
            end else if (rank_reg < upd.old_rank) begin
                rank_reg <= rank_reg + rank_t'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page replacement over a row of frame cells
// ----------------------------------------------------------------------------
// usage
//   s_axis: one word per page reference, s_tdata holds page_number
//   m_axis: one word per reference with hit flag, frame used, evicted page
//           and the saturating hit and miss counts including this reference
//   the reference is looked up by a chain of frame cells: each cell passes
//   its lookup record (first hit, first empty frame, oldest frame) to the
//   next, and the chosen frame and its old rank are broadcast back so every
//   cell updates its rank in the same edge
//   the result word is registered and is valid in the cycle after the reference word is taken
//   throughput: one word per cycle while m_axis takes the results, set by the single pass of the cell chain
//   the result sits in an output register; while it waits, a new word is
//   taken only in a cycle where the waiting word is also taken, so a stall
//   on m_axis holds s_tready low and nothing is lost
//   reset (aresetn low, synchronous): all frames empty, rank of frame i is
//   i, both counts zero, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] page_number
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // [0] hit, [2:1] frame_index,
                                        // [3] evicted_valid, [11:4] evicted_page,
                                        // [43:12] hit_total, [75:44] miss_total,
                                        // [79:76] zero
);
    import lrupr_pkg::*;

    page_t page_in;
    scan_t scan_chain [NUM_FRAMES+1];
    scan_t scan_last;
    upd_t  upd;

    logic                 accept;
    logic                 found;
    logic                 evict;
    frame_idx_t           chosen;
    rank_t                old_rank;

    logic [COUNT_W-1:0]   hit_cnt_reg,  hit_cnt_next;
    logic [COUNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    assign page_in  = page_t'(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign scan_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FRAMES; gi++) begin : g_cell
            lrupr_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (frame_idx_t'(gi)),
                .page_in  (page_in),
                .scan_in  (scan_chain[gi]),
                .scan_out (scan_chain[gi+1]),
                .upd      (upd)
            );
        end
    endgenerate

    assign scan_last = scan_chain[NUM_FRAMES];

    // pick the frame: hit, else first empty, else least recent
    always_comb begin
        found = scan_last.hit;
        evict = 1'b0;
        if (scan_last.hit) begin
            chosen   = scan_last.hit_idx;
            old_rank = scan_last.hit_rank;
        end else if (scan_last.empty) begin
            chosen   = scan_last.empty_idx;
            old_rank = scan_last.empty_rank;
        end else begin
            chosen   = scan_last.best_idx;
            old_rank = scan_last.best_rank;
            evict    = 1'b1;
        end
    end

    always_comb begin
        upd.en       = accept;
        upd.load     = !found;
        upd.chosen   = chosen;
        upd.old_rank = old_rank;
        upd.page     = page_in;
    end

    // saturating counts
    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (found) begin
            if (hit_cnt_reg != '1) begin
                hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
            end
        end else begin
            if (miss_cnt_reg != '1) begin
                miss_cnt_next = miss_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        out_data_next         = '0;
        out_data_next[0]      = found;
        out_data_next[2:1]    = INDEX_W'(chosen);
        out_data_next[3]      = evict;
        out_data_next[11:4]   = evict ? PAGE_W'(scan_last.best_page) : '0;
        out_data_next[43:12]  = hit_cnt_next;
        out_data_next[75:44]  = miss_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
